@@ hw/rtl/bki_pkg.sv @@
// shared constants, types and step functions for the bezier inbetween pipeline
`timescale 1ns / 1ps
`default_nettype none

package bki_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int COUNT_WIDTH   = 8;

    // control point numerator, curve values, lerp difference and product widths
    localparam int NUM_W = VALUE_WIDTH + 3;
    localparam int LV_W  = VALUE_WIDTH + 2;
    localparam int DF_W  = VALUE_WIDTH + 3;
    localparam int PR_W  = DF_W + FRACTION_BITS + 1;

    // divide by three: radix-4 digits spread over the divider stages
    localparam int DIV_STAGES = 3;
    localparam int D3_DIGITS  = (NUM_W + 2) / 2;
    localparam int D3_PER     = (D3_DIGITS + DIV_STAGES - 1) / DIV_STAGES;
    localparam int MP_W       = 2 * DIV_STAGES * D3_PER;

    // t divider: quotient bits per divider stage
    localparam int TD_PER = (FRACTION_BITS + DIV_STAGES - 1) / DIV_STAGES;

    // pipeline shape
    localparam int FRONT_STAGES = DIV_STAGES + 2;
    localparam int LANE_STAGES  = 3;
    localparam int LERP_LEVELS  = 3;
    localparam int NSTAGE       = FRONT_STAGES + LERP_LEVELS * LANE_STAGES + 1;

    localparam logic [MP_W-1:0]  DIV3_BIAS = MP_W'(3) << (NUM_W - 1);
    localparam logic [NUM_W-1:0] DIV3_OFF  = NUM_W'(1) << (NUM_W - 1);

    localparam logic [1:0] KIND_INTERIOR = 2'd0;
    localparam logic [1:0] KIND_FIRST    = 2'd1;
    localparam logic [1:0] KIND_LAST     = 2'd2;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic signed [LV_W-1:0]        lval_t;
    typedef logic [FRACTION_BITS-1:0]      frac_t;
    typedef logic [COUNT_WIDTH-1:0]        count_t;
    typedef logic [COUNT_WIDTH:0]          divisor_t;

    typedef struct packed {
        logic d;
        logic m;
        logic a;
    } lane_en_t;

    typedef struct packed {
        logic [MP_W-1:0] wa;
        logic [1:0]      ra;
        logic [MP_W-1:0] wb;
        logic [1:0]      rb;
        count_t          trem;
        frac_t           tq;
        value_t          s;
        value_t          e;
        logic            last;
    } front_t;

    // one radix-4 digit of a divide by three: returns {quotient digit, remainder}
    function automatic logic [3:0] div3_digit(input logic [3:0] cur);
        logic [1:0] q;
        logic [3:0] rr;
        if (cur >= 4'd9) begin
            q = 2'd3;
        end else if (cur >= 4'd6) begin
            q = 2'd2;
        end else if (cur >= 4'd3) begin
            q = 2'd1;
        end else begin
            q = 2'd0;
        end
        rr = cur - ({1'b0, q, 1'b0} + {2'b00, q});
        return {q, rr[1:0]};
    endfunction

    // one divider stage: a slice of both divide-by-three chains and of the t divider
    function automatic front_t div_pass(input front_t x, input divisor_t d, input int stage);
        front_t     y;
        logic [3:0] ga;
        logic [3:0] gb;
        divisor_t   r2;
        logic       tb;
        y = x;
        for (int i = 0; i < D3_PER; i++) begin
            ga   = div3_digit({y.ra, y.wa[MP_W-1 -: 2]});
            y.wa = {y.wa[MP_W-3:0], ga[3:2]};
            y.ra = ga[1:0];
            gb   = div3_digit({y.rb, y.wb[MP_W-1 -: 2]});
            y.wb = {y.wb[MP_W-3:0], gb[3:2]};
            y.rb = gb[1:0];
        end
        for (int i = 0; i < TD_PER; i++) begin
            if (stage * TD_PER + i < FRACTION_BITS) begin
                r2 = {y.trem, 1'b0};
                if (r2 >= d) begin
                    r2 = r2 - d;
                    tb = 1'b1;
                end else begin
                    tb = 1'b0;
                end
                y.trem = r2[COUNT_WIDTH-1:0];
                y.tq   = {y.tq[FRACTION_BITS-2:0], tb};
            end
        end
        return y;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bezier_keyframe_inbetween.sv @@
// top level: cubic bezier inbetweening of one keyframe channel, fully pipelined
`timescale 1ns / 1ps
`default_nettype none

// One word in, one word out, one word per clock sustained while out_stall is low. On its
// way from acceptance to out_valid a word passes these stages: one stage forms the control
// point numerators and clamps the frame, three stages divide by three (radix-4) and form
// t = frame/(N+1) (radix-2 restoring, about six quotient bits a stage), one stage adds the
// control points, then three de casteljau levels of three stages each (difference,
// multiply, add) and a final saturating output register. The pipeline depth is set by that
// chain of dependent lerps, each with its own multiplier. Every stage holds only when the
// stage behind it is full and held, so bubbles are squeezed out and in_stall rises only
// once the whole pipe is full and out_stall is high. inbetween_count resets to 1 and must
// only be written while the pipe is empty; a count of zero gives the start value.
module bezier_keyframe_inbetween (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   inbetween_count_wr,
    input  wire logic [bki_pkg::COUNT_WIDTH-1:0]        inbetween_count,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic signed [bki_pkg::VALUE_WIDTH-1:0] prev_value,
    input  wire logic signed [bki_pkg::VALUE_WIDTH-1:0] start_value,
    input  wire logic signed [bki_pkg::VALUE_WIDTH-1:0] end_value,
    input  wire logic signed [bki_pkg::VALUE_WIDTH-1:0] next_value,
    input  wire logic [1:0]                             segment_kind,
    input  wire logic [bki_pkg::COUNT_WIDTH-1:0]        frame_index,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic signed [bki_pkg::VALUE_WIDTH-1:0]      interp_value
);

    localparam int NS    = bki_pkg::NSTAGE;
    localparam int FS    = bki_pkg::FRONT_STAGES;
    localparam int LS    = bki_pkg::LANE_STAGES;
    localparam int TP_LO = FS + 1;
    localparam int TP_HI = FS + bki_pkg::LERP_LEVELS * LS - 2;

    localparam logic [bki_pkg::VALUE_WIDTH-1:0] SAT_MAX = {1'b0, {(bki_pkg::VALUE_WIDTH-1){1'b1}}};
    localparam logic [bki_pkg::VALUE_WIDTH-1:0] SAT_MIN = {1'b1, {(bki_pkg::VALUE_WIDTH-1){1'b0}}};

    bki_pkg::count_t   cnt_reg;
    logic [NS:1]       vld_reg;
    logic [NS:1]       en;
    bki_pkg::frac_t    tp_reg [TP_LO:TP_HI];

    bki_pkg::lval_t    a5, b5, s5, e5;
    bki_pkg::frac_t    t5;
    bki_pkg::lval_t    q0, q1, q2, r0, r1, res;
    bki_pkg::lane_en_t len1, len2, len3;

    logic [bki_pkg::LV_W-bki_pkg::VALUE_WIDTH:0] res_top;
    logic [bki_pkg::VALUE_WIDTH-1:0]             sat_next;
    logic [bki_pkg::VALUE_WIDTH-1:0]             out_reg;

    // inbetween count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= bki_pkg::count_t'(1);
        end
        else if (inbetween_count_wr)
        begin
            cnt_reg <= inbetween_count;
        end
    end

    // a stage loads when it is empty or its contents move on
    always_comb
    begin
        en[NS] = !vld_reg[NS] || !out_stall;
        for (int k = NS - 1; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_stall = !en[1];

    // valid bits travel alongside the payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                vld_reg[1] <= in_valid;
            end
            for (int k = 2; k <= NS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    bki_front u_front (
        .clk         (clk),
        .en          (en[FS:1]),
        .n           (cnt_reg),
        .prev_value  (prev_value),
        .start_value (start_value),
        .end_value   (end_value),
        .next_value  (next_value),
        .segment_kind(segment_kind),
        .frame_index (frame_index),
        .a           (a5),
        .b           (b5),
        .s           (s5),
        .e           (e5),
        .t           (t5)
    );

    // t follows the lerp levels, each multiplier takes it from the stage before
    always_ff @(posedge clk)
    begin
        if (en[TP_LO])
        begin
            tp_reg[TP_LO] <= t5;
        end
        for (int k = TP_LO + 1; k <= TP_HI; k++)
        begin
            if (en[k])
            begin
                tp_reg[k] <= tp_reg[k-1];
            end
        end
    end

    assign len1 = '{d: en[FS+1],      m: en[FS+2],      a: en[FS+3]};
    assign len2 = '{d: en[FS+LS+1],   m: en[FS+LS+2],   a: en[FS+LS+3]};
    assign len3 = '{d: en[FS+2*LS+1], m: en[FS+2*LS+2], a: en[FS+2*LS+3]};

    // first level: q0, q1, q2
    bki_lerp_lane u_lane_q0 (.clk(clk), .en(len1), .u(s5), .v(a5), .t(tp_reg[FS+1]), .y(q0));
    bki_lerp_lane u_lane_q1 (.clk(clk), .en(len1), .u(a5), .v(b5), .t(tp_reg[FS+1]), .y(q1));
    bki_lerp_lane u_lane_q2 (.clk(clk), .en(len1), .u(b5), .v(e5), .t(tp_reg[FS+1]), .y(q2));

    // second level: r0, r1
    bki_lerp_lane u_lane_r0 (.clk(clk), .en(len2), .u(q0), .v(q1), .t(tp_reg[FS+LS+1]), .y(r0));
    bki_lerp_lane u_lane_r1 (.clk(clk), .en(len2), .u(q1), .v(q2), .t(tp_reg[FS+LS+1]), .y(r1));

    // last level: the curve point
    bki_lerp_lane u_lane_res (.clk(clk), .en(len3), .u(r0), .v(r1), .t(tp_reg[FS+2*LS+1]), .y(res));

    // saturate to the value range
    always_comb
    begin
        res_top = res[bki_pkg::LV_W-1:bki_pkg::VALUE_WIDTH-1];
        if ((&res_top) || !(|res_top))
        begin
            sat_next = res[bki_pkg::VALUE_WIDTH-1:0];
        end
        else if (res[bki_pkg::LV_W-1])
        begin
            sat_next = SAT_MIN;
        end
        else
        begin
            sat_next = SAT_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NS])
        begin
            out_reg <= sat_next;
        end
    end

    assign out_valid    = vld_reg[NS];
    assign interp_value = $signed(out_reg);

    // input holds off only when every stage is occupied
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&vld_reg))
        else $error("input stalled with a bubble in the pipeline");

    // an unstalled output lets every stage advance
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("pipeline held although the output is free");

    // a word in the last lerp stage reaches the output when that stage advances
    a_reach_out: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NS-1] && en[NS]) |=> out_valid)
        else $error("word lost before the output register");

endmodule

`default_nettype wire

@@ hw/rtl/bki_front.sv @@
// front end: control point numerators, divide by three and t divider, control points
`timescale 1ns / 1ps
`default_nettype none

module bki_front (
    input  wire logic                                   clk,
    input  wire logic [bki_pkg::FRONT_STAGES-1:0]       en,
    input  wire bki_pkg::count_t                        n,
    input  wire logic signed [bki_pkg::VALUE_WIDTH-1:0] prev_value,
    input  wire logic signed [bki_pkg::VALUE_WIDTH-1:0] start_value,
    input  wire logic signed [bki_pkg::VALUE_WIDTH-1:0] end_value,
    input  wire logic signed [bki_pkg::VALUE_WIDTH-1:0] next_value,
    input  wire logic [1:0]                             segment_kind,
    input  wire logic [bki_pkg::COUNT_WIDTH-1:0]        frame_index,
    output bki_pkg::lval_t                              a,
    output bki_pkg::lval_t                              b,
    output bki_pkg::lval_t                              s,
    output bki_pkg::lval_t                              e,
    output bki_pkg::frac_t                              t
);

    logic signed [bki_pkg::NUM_W-1:0] p_x, s_x, e_x, x_x;
    logic signed [bki_pkg::NUM_W-1:0] ep_diff, xs_diff, na, nb;
    logic                             kind_first, kind_last;
    bki_pkg::count_t                  f_clamp;
    bki_pkg::divisor_t                d;
    bki_pkg::front_t                  st1_next;
    bki_pkg::front_t                  st_reg [0:bki_pkg::DIV_STAGES];

    logic signed [bki_pkg::NUM_W-1:0] qa, qb, a_w, b_w;
    bki_pkg::lval_t                   a_reg, b_reg, s_reg, e_reg;
    bki_pkg::frac_t                   t_reg;

    assign d = bki_pkg::divisor_t'(n) + bki_pkg::divisor_t'(1);

    always_comb
    begin
        p_x = bki_pkg::NUM_W'(prev_value);
        s_x = bki_pkg::NUM_W'(start_value);
        e_x = bki_pkg::NUM_W'(end_value);
        x_x = bki_pkg::NUM_W'(next_value);
        kind_first = (segment_kind == bki_pkg::KIND_FIRST);
        kind_last  = (segment_kind == bki_pkg::KIND_LAST);
        ep_diff = e_x - p_x;
        xs_diff = x_x - s_x;
        // sixths go as a floor halving followed by a floor third
        na = kind_first ? (e_x + e_x - x_x - s_x) : (ep_diff >>> 1);
        nb = kind_last  ? (s_x + s_x - p_x - e_x) : (xs_diff >>> 1);
        f_clamp = (frame_index > n) ? n : frame_index;

        st1_next.wa   = bki_pkg::MP_W'(na) + bki_pkg::DIV3_BIAS;
        st1_next.ra   = 2'd0;
        st1_next.wb   = bki_pkg::MP_W'(nb) + bki_pkg::DIV3_BIAS;
        st1_next.rb   = 2'd0;
        st1_next.trem = f_clamp;
        st1_next.tq   = '0;
        st1_next.s    = start_value;
        st1_next.e    = end_value;
        st1_next.last = kind_last;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            st_reg[0] <= st1_next;
        end
        for (int k = 1; k <= bki_pkg::DIV_STAGES; k++)
        begin
            if (en[k])
            begin
                st_reg[k] <= bki_pkg::div_pass(st_reg[k-1], d, k - 1);
            end
        end
    end

    // remove the bias third and form the inner control points
    always_comb
    begin
        qa  = $signed(st_reg[bki_pkg::DIV_STAGES].wa[bki_pkg::NUM_W-1:0] - bki_pkg::DIV3_OFF);
        qb  = $signed(st_reg[bki_pkg::DIV_STAGES].wb[bki_pkg::NUM_W-1:0] - bki_pkg::DIV3_OFF);
        a_w = bki_pkg::NUM_W'($signed(st_reg[bki_pkg::DIV_STAGES].s)) + qa;
        b_w = st_reg[bki_pkg::DIV_STAGES].last
            ? bki_pkg::NUM_W'($signed(st_reg[bki_pkg::DIV_STAGES].e)) + qb
            : bki_pkg::NUM_W'($signed(st_reg[bki_pkg::DIV_STAGES].e)) - qb;
    end

    always_ff @(posedge clk)
    begin
        if (en[bki_pkg::FRONT_STAGES-1])
        begin
            a_reg <= a_w[bki_pkg::LV_W-1:0];
            b_reg <= b_w[bki_pkg::LV_W-1:0];
            s_reg <= bki_pkg::LV_W'($signed(st_reg[bki_pkg::DIV_STAGES].s));
            e_reg <= bki_pkg::LV_W'($signed(st_reg[bki_pkg::DIV_STAGES].e));
            t_reg <= st_reg[bki_pkg::DIV_STAGES].tq;
        end
    end

    assign a = a_reg;
    assign b = b_reg;
    assign s = s_reg;
    assign e = e_reg;
    assign t = t_reg;

endmodule

`default_nettype wire

@@ hw/rtl/bki_lerp_lane.sv @@
// one de casteljau lerp lane: difference, multiply, add, one register each
`timescale 1ns / 1ps
`default_nettype none

module bki_lerp_lane (
    input  wire logic              clk,
    input  wire bki_pkg::lane_en_t en,
    input  wire bki_pkg::lval_t    u,
    input  wire bki_pkg::lval_t    v,
    input  wire bki_pkg::frac_t    t,
    output bki_pkg::lval_t         y
);

    logic signed [bki_pkg::DF_W-1:0]   d_reg, d_next;
    bki_pkg::lval_t                    u1_reg, u2_reg, y_reg;
    logic signed [bki_pkg::PR_W-1:0]   p_reg, p_next;
    logic signed [bki_pkg::DF_W:0]     sh;
    logic signed [bki_pkg::DF_W:0]     sum;

    always_comb
    begin
        d_next = bki_pkg::DF_W'(v) - bki_pkg::DF_W'(u);
        p_next = bki_pkg::PR_W'(d_reg) * bki_pkg::PR_W'($signed({1'b0, t}));
        // arithmetic shift gives the floor of the scaled product
        sh     = p_reg[bki_pkg::PR_W-1:bki_pkg::FRACTION_BITS];
        sum    = sh + (bki_pkg::DF_W + 1)'(u2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en.d)
        begin
            d_reg  <= d_next;
            u1_reg <= u;
        end
        if (en.m)
        begin
            p_reg  <= p_next;
            u2_reg <= u1_reg;
        end
        if (en.a)
        begin
            y_reg <= sum[bki_pkg::LV_W-1:0];
        end
    end

    assign y = y_reg;

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// testbench for the bezier keyframe inbetween pipeline: directed and random words, scoreboard check
`timescale 1ns / 1ps

module tb;

    localparam int              WATCHDOG_LIMIT = 4000;
    localparam int              PRESSURE_HOLD  = 150;
    localparam int              DRAIN_PAUSE    = 25;
    localparam bki_pkg::value_t VALUE_MAX      = 32'sh7fff_ffff;
    localparam bki_pkg::value_t VALUE_MIN      = 32'sh8000_0000;
    // segment kind code with no meaning of its own, taken as interior
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // one input word as the sender holds it
    typedef struct {
        bki_pkg::value_t prev_v;
        bki_pkg::value_t start_v;
        bki_pkg::value_t end_v;
        bki_pkg::value_t next_v;
        logic [1:0]      kind;
        bki_pkg::count_t frame;
    } key_word_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    // block ports, all known from time zero
    logic            inbetween_count_wr = 1'b0;
    bki_pkg::count_t inbetween_count    = '0;
    logic            in_valid           = 1'b0;
    logic            in_stall;
    bki_pkg::value_t prev_value         = '0;
    bki_pkg::value_t start_value        = '0;
    bki_pkg::value_t end_value          = '0;
    bki_pkg::value_t next_value         = '0;
    logic [1:0]      segment_kind       = '0;
    bki_pkg::count_t frame_index        = '0;
    logic            out_valid;
    logic            out_stall          = 1'b0;
    bki_pkg::value_t interp_value;

    bezier_keyframe_inbetween dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .inbetween_count_wr (inbetween_count_wr),
        .inbetween_count    (inbetween_count),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .prev_value         (prev_value),
        .start_value        (start_value),
        .end_value          (end_value),
        .next_value         (next_value),
        .segment_kind       (segment_kind),
        .frame_index        (frame_index),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .interp_value       (interp_value)
    );

    // words waiting to be sent, and curve values waiting to come out
    key_word_t       key_words[$];
    bki_pkg::value_t curve_values_due[$];

    // shadow of the inbetween count register, as the block should hold it
    bki_pkg::count_t count_shadow = 8'd1;

    int words_queued    = 0;
    int words_accepted  = 0;
    int values_checked  = 0;
    int mismatch_count  = 0;

    // handshake bookkeeping shared between the clock edges
    logic in_taken      = 1'b0;
    logic sender_burst  = 1'b0;
    logic pressure_req  = 1'b0;
    logic pressure_done = 1'b0;

    // ------------------------------------------------------------------
    // curve prediction
    // ------------------------------------------------------------------

    // division rounded towards minus infinity
    function automatic longint div_floor(input longint num, input longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        return q;
    endfunction

    // u + floor((v - u) * t / 2^FRACTION_BITS); the shift is arithmetic so it floors
    function automatic longint lerp_fixed(input longint u, input longint v, input longint t);
        return u + (((v - u) * t) >>> bki_pkg::FRACTION_BITS);
    endfunction

    // the inbetween value for one word under inbetween count n
    function automatic bki_pkg::value_t predict_curve(input key_word_t w,
                                                      input bki_pkg::count_t n);
        longint p, s, e, x;
        longint nn, f, t;
        longint a, b, q0, q1, q2, r0, r1, res;
        p  = longint'(w.prev_v);
        s  = longint'(w.start_v);
        e  = longint'(w.end_v);
        x  = longint'(w.next_v);
        nn = longint'(n);
        f  = longint'(w.frame);
        // frames past the count are pinned to the last inbetween
        if (f > nn)
            f = nn;
        t = (f << bki_pkg::FRACTION_BITS) / (nn + 1);
        if (w.kind == bki_pkg::KIND_FIRST) begin
            // start tangent reflects the next key
            a = s + div_floor(2 * e - x - s, 3);
            b = e - div_floor(x - s, 6);
        end else if (w.kind == bki_pkg::KIND_LAST) begin
            // end tangent reflects the previous key
            a = s + div_floor(e - p, 6);
            b = e + div_floor(2 * s - p - e, 3);
        end else begin
            // interior, and the unused code too
            a = s + div_floor(e - p, 6);
            b = e - div_floor(x - s, 6);
        end
        // de casteljau, three levels
        q0  = lerp_fixed(s, a, t);
        q1  = lerp_fixed(a, b, t);
        q2  = lerp_fixed(b, e, t);
        r0  = lerp_fixed(q0, q1, t);
        r1  = lerp_fixed(q1, q2, t);
        res = lerp_fixed(r0, r1, t);
        if (res > longint'(VALUE_MAX))
            res = longint'(VALUE_MAX);
        if (res < longint'(VALUE_MIN))
            res = longint'(VALUE_MIN);
        return bki_pkg::value_t'(res);
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // idle length: mostly none or short, now and then long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // any key value, weighted towards the range limits and the sign boundary
    function automatic bki_pkg::value_t any_value();
        case ($urandom_range(0, 7))
            0, 1, 2: return bki_pkg::value_t'($urandom);
            3:       return VALUE_MAX;
            4:       return VALUE_MIN;
            5:       return bki_pkg::value_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
            6:       return {($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000,
                             16'($urandom)};
            default: return ($urandom_range(0, 1) != 0) ? bki_pkg::value_t'(0)
                                                         : bki_pkg::value_t'(-1);
        endcase
    endfunction

    // a frame number that a well formed track would use
    function automatic bki_pkg::count_t track_frame(input bki_pkg::count_t n);
        case ($urandom_range(0, 9))
            0:       return 8'd1;
            1:       return n;
            default: return bki_pkg::count_t'($urandom_range(1, (n == 0) ? 1 : n));
        endcase
    endfunction

    task automatic queue_word(input bki_pkg::value_t prev_v, input bki_pkg::value_t start_v,
                              input bki_pkg::value_t end_v, input bki_pkg::value_t next_v,
                              input logic [1:0] kind, input bki_pkg::count_t frame);
        key_word_t w;
        w.prev_v  = prev_v;
        w.start_v = start_v;
        w.end_v   = end_v;
        w.next_v  = next_v;
        w.kind    = kind;
        w.frame   = frame;
        key_words.push_back(w);
        words_queued++;
    endtask

    // a short keyframe track walked segment by segment, a few inbetweens per segment
    task automatic queue_track(input bki_pkg::count_t n);
        bki_pkg::value_t keys[6];
        int              m;
        int              k;
        logic [1:0]      kind;
        bki_pkg::value_t p;
        bki_pkg::value_t x;
        m = $urandom_range(2, 6);
        keys[0] = ($urandom_range(0, 3) == 0)
                  ? any_value()
                  : bki_pkg::value_t'($urandom) >>> $urandom_range(2, 8);
        for (int i = 1; i < m; i++) begin
            if ($urandom_range(0, 4) == 0)
                keys[i] = any_value();
            else
                keys[i] = keys[i-1] + (bki_pkg::value_t'($urandom) >>> $urandom_range(4, 20));
        end
        for (int i = 0; i + 1 < m; i++) begin
            if (i == 0)
                kind = bki_pkg::KIND_FIRST;
            else if (i == m - 2)
                kind = bki_pkg::KIND_LAST;
            else
                kind = bki_pkg::KIND_INTERIOR;
            // operands the segment kind ignores get noise
            p = (i == 0) ? any_value() : keys[i-1];
            x = (i + 2 < m) ? keys[i+2] : any_value();
            k = $urandom_range(1, 4);
            for (int j = 0; j < k; j++)
                queue_word(p, keys[i], keys[i+1], x, kind, track_frame(n));
        end
    endtask

    task automatic queue_noise();
        queue_word(any_value(), any_value(), any_value(), any_value(),
                   2'($urandom_range(0, 3)), bki_pkg::count_t'($urandom_range(0, 255)));
    endtask

    // register writes only happen with the pipe empty
    task automatic write_count(input bki_pkg::count_t n);
        @(negedge clk);
        inbetween_count_wr <= 1'b1;
        inbetween_count    <= n;
        count_shadow        = n;
        @(negedge clk);
        inbetween_count_wr <= 1'b0;
    endtask

    // wait until every queued word has gone in and its value has come out, then let the pipe settle
    task automatic wait_drained();
        while (!(words_accepted == words_queued && values_checked == words_accepted))
            @(negedge clk);
        repeat (DRAIN_PAUSE) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // sender: presents words from the queue, changes only on the falling edge
    // ------------------------------------------------------------------
    int        gap_left   = 0;
    int        burst_left = 0;
    key_word_t next_word;

    always @(negedge clk) begin
        // payload only moves once the word on the bus has been taken
        if (!in_valid || in_taken) begin
            if (gap_left != 0) begin
                in_valid <= 1'b0;
                gap_left--;
            end else if (key_words.size() != 0) begin
                next_word = key_words.pop_front();
                prev_value   <= next_word.prev_v;
                start_value  <= next_word.start_v;
                end_value    <= next_word.end_v;
                next_value   <= next_word.next_v;
                segment_kind <= next_word.kind;
                frame_index  <= next_word.frame;
                in_valid     <= 1'b1;
                // gap to leave after this word, with the odd run of back to back words
                if (sender_burst) begin
                    gap_left = 0;
                end else if (burst_left != 0) begin
                    burst_left--;
                    gap_left = 0;
                end else begin
                    if ($urandom_range(0, 19) == 0)
                        burst_left = $urandom_range(20, 60);
                    gap_left = pick_idle();
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall, plus one long hold-off that backs the pipe up
    // ------------------------------------------------------------------
    int hold_left = 0;
    int free_left = 0;

    always @(negedge clk) begin
        if (pressure_req && !pressure_done) begin
            pressure_done = 1'b1;
            hold_left     = PRESSURE_HOLD;
            free_left     = 0;
        end
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else if (free_left != 0) begin
            out_stall <= 1'b0;
            free_left--;
        end else if ($urandom_range(0, 3) == 0) begin
            // a stretch with no stall at all
            free_left = $urandom_range(10, 60);
            out_stall <= 1'b0;
        end else begin
            hold_left = pick_idle();
            out_stall <= (hold_left != 0);
            if (hold_left != 0)
                hold_left--;
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks results first, then books the accepted input word, so a
    // word can never meet its own result in the same edge
    // ------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        key_word_t       seen;
        bki_pkg::value_t due;
        in_taken = in_valid && !in_stall;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                values_checked++;
                if (curve_values_due.size() == 0) begin
                    $display("%0t: interp_value %0d with no word outstanding",
                             $time, interp_value);
                    mismatch_count++;
                end else begin
                    due = curve_values_due.pop_front();
                    if (interp_value !== due) begin
                        $display("%0t: interp_value mismatch, expected %0d got %0d",
                                 $time, due, interp_value);
                        mismatch_count++;
                    end
                end
            end
            if (in_taken) begin
                seen.prev_v  = prev_value;
                seen.start_v = start_value;
                seen.end_v   = end_value;
                seen.next_v  = next_value;
                seen.kind    = segment_kind;
                seen.frame   = frame_index;
                curve_values_due.push_back(predict_curve(seen, count_shadow));
                words_accepted++;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long with nothing moving on either side ends the run
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: timeout, nothing moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // sequence of phases
    // ------------------------------------------------------------------
    initial begin : sequencer
        bki_pkg::count_t phase_counts[8];
        int              phase_words;
        int              first_word;
        phase_counts = '{8'd255, 8'd0, 8'd2, 8'd7, 8'd128,
                         bki_pkg::count_t'($urandom_range(3, 254)), 8'd1, 8'd64};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words under the reset count of one, so t is a half
        queue_word('0, '0, '0, '0, bki_pkg::KIND_INTERIOR, 8'd1);
        queue_word(VALUE_MAX, VALUE_MAX, VALUE_MAX, VALUE_MAX, bki_pkg::KIND_INTERIOR, 8'd1);
        queue_word(VALUE_MIN, VALUE_MIN, VALUE_MIN, VALUE_MIN, bki_pkg::KIND_INTERIOR, 8'd1);
        // control points pushed past the range: saturate high and low
        queue_word(VALUE_MIN, VALUE_MAX, VALUE_MAX, VALUE_MIN, bki_pkg::KIND_INTERIOR, 8'd1);
        queue_word(VALUE_MAX, VALUE_MIN, VALUE_MIN, VALUE_MAX, bki_pkg::KIND_INTERIOR, 8'd1);
        // first segment, previous key is noise
        queue_word(any_value(), VALUE_MIN, VALUE_MAX, VALUE_MIN, bki_pkg::KIND_FIRST, 8'd1);
        queue_word(any_value(), VALUE_MAX, VALUE_MIN, VALUE_MAX, bki_pkg::KIND_FIRST, 8'd1);
        // last segment, next key is noise
        queue_word(VALUE_MAX, VALUE_MAX, VALUE_MIN, any_value(), bki_pkg::KIND_LAST, 8'd1);
        queue_word(VALUE_MIN, VALUE_MIN, VALUE_MAX, any_value(), bki_pkg::KIND_LAST, 8'd1);
        // unused kind code behaves as interior
        queue_word(32'sh0001_0000, 32'sh0003_0000, 32'shfffe_0000, 32'sh0010_8000,
                   KIND_UNUSED, 8'd1);
        queue_word(VALUE_MIN, VALUE_MAX, VALUE_MAX, VALUE_MIN, KIND_UNUSED, 8'd1);
        // frame zero gives the start value, frames past the count are pinned
        queue_word(VALUE_MAX, 32'sh1234_5678, VALUE_MIN, VALUE_MAX,
                   bki_pkg::KIND_INTERIOR, 8'd0);
        queue_word(any_value(), any_value(), any_value(), any_value(),
                   bki_pkg::KIND_LAST, 8'd0);
        queue_word(32'sh0002_0000, 32'sh0004_0000, 32'sh0008_0000, 32'sh0010_0000,
                   bki_pkg::KIND_INTERIOR, 8'd255);
        queue_word(any_value(), any_value(), any_value(), any_value(),
                   bki_pkg::KIND_FIRST, 8'd2);
        // alternating bit patterns
        queue_word(32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555,
                   bki_pkg::KIND_INTERIOR, 8'haa);
        queue_word(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa,
                   bki_pkg::KIND_LAST, 8'h55);
        queue_word(-1, -1, -1, -1, bki_pkg::KIND_FIRST, 8'd1);
        queue_word(32'shffff_8000, 32'sh0000_8000, 32'shffff_ffff, 32'sh0000_0001,
                   bki_pkg::KIND_INTERIOR, 8'd1);
        wait_drained();

        // random phases, one count setting each
        foreach (phase_counts[i]) begin
            write_count(phase_counts[i]);
            phase_words = (phase_counts[i] == 0) ? 60 : 165;
            first_word  = words_queued;
            // phase three runs back to back against a long receiver hold-off
            sender_burst = (i == 3);
            while (words_queued - first_word < phase_words) begin
                if ($urandom_range(0, 99) < 85)
                    queue_track(phase_counts[i]);
                else
                    queue_noise();
            end
            if (i == 3)
                pressure_req = 1'b1;
            wait_drained();
            sender_burst = 1'b0;
        end

        if (mismatch_count == 0 && curve_values_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/bki_pkg.sv
hw/rtl/bki_front.sv
hw/rtl/bki_lerp_lane.sv
hw/rtl/bezier_keyframe_inbetween.sv
tb/sv/tb.sv
